// ===== hw/rtl/kpq_pkg.sv =====
`timescale 1ns / 1ps
package kpq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [KEY_BITS-1:0]     t_key;
    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [CAPACITY-1:0]     t_vec;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_UPD = 2'd1;
    localparam logic [1:0] OP_DEQ = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic   rm;     // close the gap at the matched key
        logic   deq;    // close the gap at the head
        logic   ins;    // open a gap at the sorted place and fill it
        t_key   key;
        t_value value;
    } t_chain_ctl;

    typedef struct packed {
        logic   found;
        t_key   head_key;
        t_value head_value;
    } t_chain_sts;

    // Inclusive prefix OR, bit i set when any bit at or below i is set.
    function automatic t_vec prefix_or(input t_vec v);
        t_vec acc;
        acc = v;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            acc = acc | (acc << s);
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/kpq_cell.sv =====
`timescale 1ns / 1ps
module kpq_cell
    import kpq_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  logic       i_occ,
    input  logic       i_rm_here,
    input  logic       i_lt_left,
    input  t_key       i_left_key,
    input  t_value     i_left_value,
    input  t_key       i_right_key,
    input  t_value     i_right_value,
    output t_key       o_key,
    output t_value     o_value,
    output logic       o_match,
    output logic       o_lt
);

    t_key   r_key;
    t_value r_value;

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = i_occ && (r_key == i_ctl.key);
    assign o_lt    = i_occ && ($signed(r_value) < $signed(i_ctl.value));

    always_ff @(posedge i_clk) begin
        if ((i_ctl.rm || i_ctl.deq) && i_rm_here) begin
            r_key   <= i_right_key;
            r_value <= i_right_value;
        end else if (i_ctl.ins && !o_lt) begin
            // first cell not below the new value takes it, the rest move up
            if (i_lt_left) begin
                r_key   <= i_ctl.key;
                r_value <= i_ctl.value;
            end else begin
                r_key   <= i_left_key;
                r_value <= i_left_value;
            end
        end
    end

endmodule

// ===== hw/rtl/kpq_chain.sv =====
`timescale 1ns / 1ps
module kpq_chain
    import kpq_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  t_cnt       i_count,
    output t_chain_sts o_sts
);

    t_key   w_key   [CAPACITY];
    t_value w_value [CAPACITY];
    t_vec   w_match;
    t_vec   w_lt;
    t_vec   w_rm;

    assign w_rm = i_ctl.deq ? '1 : prefix_or(w_match);

    assign o_sts.found      = |w_match;
    assign o_sts.head_key   = w_key[0];
    assign o_sts.head_value = w_value[0];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam t_cnt IDX = CNT_W'(i);
        logic   w_lt_left;
        t_key   w_lkey;
        t_value w_lvalue;
        t_key   w_rkey;
        t_value w_rvalue;

        if (i == 0) begin : g_first
            assign w_lt_left = 1'b1;
            assign w_lkey    = '0;
            assign w_lvalue  = '0;
        end else begin : g_mid
            assign w_lt_left = w_lt[i-1];
            assign w_lkey    = w_key[i-1];
            assign w_lvalue  = w_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_rkey   = w_key[i];
            assign w_rvalue = w_value[i];
        end else begin : g_inner
            assign w_rkey   = w_key[i+1];
            assign w_rvalue = w_value[i+1];
        end

        kpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_occ         (IDX < i_count),
            .i_rm_here     (w_rm[i]),
            .i_lt_left     (w_lt_left),
            .i_left_key    (w_lkey),
            .i_left_value  (w_lvalue),
            .i_right_key   (w_rkey),
            .i_right_value (w_rvalue),
            .o_key         (w_key[i]),
            .o_value       (w_value[i]),
            .o_match       (w_match[i]),
            .o_lt          (w_lt[i])
        );
    end

endmodule

// ===== hw/rtl/keyed_priority_queue.sv =====
`timescale 1ns / 1ps
// Keyed priority queue: up to CAPACITY key/value entries kept sorted by
// ascending signed value in a chain of cells, least entry at the head.
// Input channel i_valid/o_ready carries one command per transaction:
// add or update, update only, or dequeue least. Output channel
// o_valid/i_ready returns exactly one result per command: the dequeued
// entry if any, a status code, the entry count and the empty flag.
// Each command has a remove step and an insert step: at the accepting edge
// every cell compares its key and the matched entry (or the head) is removed
// by shifting the upper cells down; in the insert state every cell compares
// its value and the entry is inserted by shifting the upper cells up. No new
// command is accepted until the insert state ends; the result is visible the
// cycle after the insert cycle. The result register holds one result; while
// it is not taken the insert cycle waits, so a stalled receiver stalls the
// input after at most one further command. Reset empties the queue and
// clears both handshakes; entry contents are not cleared.
module keyed_priority_queue
    import kpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_in_key,
    input  logic signed [31:0] i_in_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_out_valid,
    output logic [15:0]        o_out_key,
    output logic signed [31:0] o_out_value,
    output logic [1:0]         o_status,
    output logic [6:0]         o_entry_count,
    output logic               o_is_empty
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_INS  = 1'b1;

    logic       r_state;
    t_cnt       r_count;
    logic       r_ins;
    logic       r_deq;
    logic [1:0] r_st;
    t_key       r_key;
    t_value     r_value;
    t_key       r_hkey;
    t_value     r_hvalue;

    logic               r_ovld;
    logic               r_out_valid;
    logic [15:0]        r_out_key;
    logic signed [31:0] r_out_value;
    logic [1:0]         r_status;
    logic [6:0]         r_entry_count;
    logic               r_is_empty;

    t_chain_ctl w_ctl;
    t_chain_sts w_sts;
    logic       w_accept;
    logic       w_commit;
    logic       n_rm;
    logic       n_deq;
    logic       n_ins;
    logic [1:0] n_st;
    t_cnt       n_count;

    assign o_ready  = i_rst_n && (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_commit = (r_state == S_INS) && (!r_ovld || i_ready);

    always_comb begin
        n_rm  = 1'b0;
        n_deq = 1'b0;
        n_ins = 1'b0;
        n_st  = ST_OK;
        case (i_opcode)
            OP_ADD, OP_UPD: begin
                if (w_sts.found) begin
                    n_rm  = 1'b1;
                    n_ins = 1'b1;
                end else if (i_opcode == OP_UPD) begin
                    n_st = ST_NOT_FOUND;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_st = ST_FULL;
                end else begin
                    n_ins = 1'b1;
                end
            end
            OP_DEQ: begin
                if (r_count == '0) begin
                    n_st = ST_EMPTY;
                end else begin
                    n_deq = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_ctl.rm    = w_accept && n_rm;
        w_ctl.deq   = w_accept && n_deq;
        w_ctl.ins   = w_commit && r_ins;
        w_ctl.key   = (r_state == S_IDLE) ? KEY_BITS'(i_in_key) : r_key;
        w_ctl.value = (r_state == S_IDLE) ? t_value'(i_in_value) : r_value;
    end

    assign n_count = r_count + CNT_W'(r_ins);

    kpq_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_count (r_count),
        .o_sts   (w_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= S_INS;
                if (n_rm || n_deq) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end else if (w_commit) begin
                r_state <= S_IDLE;
                r_count <= n_count;
            end
            if (w_commit) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ins    <= n_ins;
            r_deq    <= n_deq;
            r_st     <= n_st;
            r_key    <= KEY_BITS'(i_in_key);
            r_value  <= t_value'(i_in_value);
            r_hkey   <= w_sts.head_key;
            r_hvalue <= w_sts.head_value;
        end
        if (w_commit) begin
            r_out_valid   <= r_deq;
            r_out_key     <= r_deq ? 16'(r_hkey) : '0;
            r_out_value   <= r_deq ? 32'(r_hvalue) : '0;
            r_status      <= r_st;
            r_entry_count <= 7'(n_count);
            r_is_empty    <= (n_count == '0);
        end
    end

    assign o_valid       = r_ovld;
    assign o_out_valid   = r_out_valid;
    assign o_out_key     = r_out_key;
    assign o_out_value   = r_out_value;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("command accepted during insert cycle");

    a_deq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_out_valid) |-> (r_status == ST_OK))
        else $error("dequeued entry with error status");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_is_empty == (r_entry_count == 7'd0)))
        else $error("empty flag disagrees with entry count");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_st == ST_FULL) |=> (r_count == CNT_W'(CAPACITY)))
        else $error("dropped add changed the queue");

endmodule
